### design/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg: shared types and constants for the bounded value stack
// Operation and error codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int WORD_W  = 64;
  localparam int ACT_W   = 3;
  localparam int ERR_W   = 2;
  localparam int DEPTH_W = 8;
  localparam int IN_W    = 72;  // 3 + 64 bits, padded to bytes
  localparam int OUT_W   = 80;  // 64 + 2 + 8 bits, padded to bytes

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_DUP   = 3'd3,
    ACT_SWAP  = 3'd4,
    ACT_CLEAR = 3'd5
  } act_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_FEW   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_LOAD,
    S_SWAP_LOAD
  } state_t;

  // memory address source: pointer minus one or minus two
  typedef enum logic {
    ADDR_M1,
    ADDR_M2
  } addr_sel_t;

  typedef struct packed {
    logic      enq;            // push a result into the output queue
    err_t      err;
    logic      rd_top;         // result word is the cached top
    logic      ptr_inc;
    logic      ptr_dec;
    logic      ptr_clr;
    logic      top_from_word;
    logic      top_from_rdata;
    logic      mem_wr;         // write cached top to memory
    logic      mem_rd;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic few;
    logic full;
    logic q_full;
  } stat_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    err_t               err;
    logic [WORD_W-1:0]  value;
  } res_t;

endpackage

### design/bounded_value_stack_top.sv
// ----------------------------------------------------------------------------
// bounded_value_stack_top: bounded LIFO stack of 64-bit words
// Push, pop, peek, duplicate, swap top two and clear; one result per
// transaction carrying the word read, an error code and the new depth.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   action, push_value
// m_*       out  m_tvalid/m_tready   read_value, error_code, depth
//
// Sequencing: push, peek, duplicate, clear and every refused operation finish
// in the idle state; pop with two or more entries and swap also pass through
// a load state, after the registered read of the single-port stack memory that
// refills the cached top register (pop) or fetches the second entry (swap).
// Reset: the pointer goes to zero, the sequencer to idle and the output queue
// empties; storage is not cleared, entries are only read after being written.
// Stalls: results collect in a two-entry output queue; input is taken while
// one result waits; held off when both entries are full or a load is pending.
// ----------------------------------------------------------------------------
module bounded_value_stack_top
  import bvs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [2:0] action, [66:3] push_value, rest zero
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [63:0] read_value, [65:64] error_code,
                                      // [73:66] depth, rest zero
);

  cmd_t  cmd;
  stat_t stat;
  res_t  result;

  // sequencer: decodes the operation, owns the handshake on the input side
  bvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tdata[ACT_W-1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, pointer and output queue
  bvs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (s_tdata[ACT_W +: WORD_W]),
    .stat       (stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  // pack result, read_value in the low bits
  assign m_tdata = OUT_W'(result);

endmodule

### design/bvs_ctrl.sv
// ----------------------------------------------------------------------------
// bvs_ctrl: operation sequencer
// Decodes the accepted operation against the stack status and drives the
// datapath commands; pop (two or more entries) and swap add a memory-read load state.
// ----------------------------------------------------------------------------
module bvs_ctrl
  import bvs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ACT_W-1:0] action,
  input  stat_t            stat,
  output cmd_t             cmd
);

  state_t state;
  state_t state_next;
  logic   accept;
  act_t   act;

  assign act      = act_t'(action);
  // ready only in idle, outside reset, with room in the output queue
  assign s_tready = !rst && (state == S_IDLE) && !stat.q_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && act == ACT_POP && !stat.empty && !stat.single) begin
          state_next = S_POP_LOAD;
        end else if (accept && act == ACT_SWAP && !stat.few) begin
          state_next = S_SWAP_LOAD;
        end
      end
      S_POP_LOAD:  state_next = S_IDLE;
      S_SWAP_LOAD: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.err  = ERR_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.enq = 1'b1;
          case (act)
            ACT_PUSH: begin
              if (stat.full) begin
                cmd.err = ERR_FULL;
              end else begin
                cmd.mem_wr        = !stat.empty;
                cmd.addr_sel      = ADDR_M1;
                cmd.top_from_word = 1'b1;
                cmd.ptr_inc       = 1'b1;
              end
            end
            ACT_POP: begin
              if (stat.empty) begin
                cmd.err = ERR_EMPTY;
              end else begin
                cmd.rd_top   = 1'b1;
                cmd.ptr_dec  = 1'b1;
                cmd.mem_rd   = !stat.single;
                cmd.addr_sel = ADDR_M2;
              end
            end
            ACT_PEEK: begin
              if (stat.empty) begin
                cmd.err = ERR_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
              end
            end
            ACT_DUP: begin
              if (stat.empty) begin
                cmd.err = ERR_EMPTY;
              end else if (stat.full) begin
                cmd.err = ERR_FULL;
              end else begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = ADDR_M1;
                cmd.ptr_inc  = 1'b1;
              end
            end
            ACT_SWAP: begin
              if (stat.few) begin
                cmd.err = ERR_FEW;
              end else begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_M2;
              end
            end
            ACT_CLEAR: cmd.ptr_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_POP_LOAD: begin
        cmd.top_from_rdata = 1'b1;
      end
      S_SWAP_LOAD: begin
        // old top goes down, second entry comes up into the top register
        cmd.mem_wr         = 1'b1;
        cmd.addr_sel       = ADDR_M2;
        cmd.top_from_rdata = 1'b1;
      end
      default: ;
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input ready while a load is pending");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd.mem_rd) |=> (state == S_POP_LOAD || state == S_SWAP_LOAD))
    else $error("memory read not followed by a load cycle");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> !cmd.mem_rd)
    else $error("read and write in the same cycle");

endmodule

### design/bvs_dpath.sv
// ----------------------------------------------------------------------------
// bvs_dpath: stack storage, pointer, cached top and result queue
// The top entry lives in a register; entries below it sit in a single-port
// memory. Results pass through a two-entry output queue.
// ----------------------------------------------------------------------------
module bvs_dpath
  import bvs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [WORD_W-1:0] push_value,
  output stat_t             stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output res_t              result
);

  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [WORD_W-1:0] stack_store [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] top;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;
  logic [ADDR_W-1:0] addr;

  res_t res_new;
  res_t q0, q0_next;
  res_t q1, q1_next;
  logic v0, v0_next;
  logic v1, v1_next;
  logic deq;

  // pointer
  always_comb begin
    ptr_next = ptr;
    if (cmd.ptr_clr) begin
      ptr_next = '0;
    end else if (cmd.ptr_inc) begin
      ptr_next = ptr + PTR_W'(1);
    end else if (cmd.ptr_dec) begin
      ptr_next = ptr - PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  assign stat.empty  = (ptr == '0);
  assign stat.single = (ptr == PTR_W'(1));
  assign stat.few    = (ptr < PTR_W'(2));
  assign stat.full   = (ptr == PTR_W'(DEPTH));
  assign stat.q_full = v1;

  // cached top
  always_ff @(posedge clk) begin
    if (cmd.top_from_word) begin
      top <= push_value;
    end else if (cmd.top_from_rdata) begin
      top <= rdata;
    end
  end

  // single-port memory below the top
  assign addr = (cmd.addr_sel == ADDR_M1) ? ADDR_W'(ptr - PTR_W'(1))
                                          : ADDR_W'(ptr - PTR_W'(2));

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      stack_store[addr] <= top;
    end
    if (cmd.mem_rd) begin
      rdata <= stack_store[addr];
    end
  end

  // result of the accepted operation
  assign res_new.value = cmd.rd_top ? top : '0;
  assign res_new.err   = cmd.err;
  assign res_new.depth = DEPTH_W'(ptr_next);

  // two-entry output queue, q0 is the head
  assign deq      = v0 && m_tready;
  assign m_tvalid = v0;
  assign result   = q0;

  always_comb begin
    q0_next = q0;
    q1_next = q1;
    v0_next = v0;
    v1_next = v1;
    if (deq) begin
      q0_next = q1;
      v0_next = v1;
      v1_next = 1'b0;
    end
    if (cmd.enq) begin
      if (!v0_next) begin
        q0_next = res_new;
        v0_next = 1'b1;
      end else begin
        q1_next = res_new;
        v1_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(DEPTH))
    else $error("stack pointer beyond depth");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("queue tail valid without head");

  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |-> !v1)
    else $error("result queued with the queue full");

endmodule

### dv/bounded_value_stack_checker.sv
// ----------------------------------------------------------------------------
// bounded_value_stack_checker: scoreboard for the bounded value stack
// Watches both stream channels, keeps a shadow stack to predict the result of
// every accepted operation, and compares results field by field in order.
// ----------------------------------------------------------------------------
module bounded_value_stack_checker
  import bvs_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RES_W = DEPTH_W + ERR_W + WORD_W;

  // 2-state counters start at zero
  logic [WORD_W-1:0] shadow_words [DEPTH];
  int unsigned       shadow_ptr;
  res_t              expected_results [$];

  // Apply one operation to the shadow stack and return the result it yields.
  // Refused operations leave the shadow untouched.
  function automatic res_t stack_apply(logic [ACT_W-1:0] op, logic [WORD_W-1:0] word);
    res_t              r;
    logic [WORD_W-1:0] tmp;
    r.value = '0;
    r.err   = ERR_OK;
    case (op)
      ACT_PUSH: begin
        if (shadow_ptr < DEPTH) begin
          shadow_words[shadow_ptr] = word;
          shadow_ptr++;
        end else begin
          r.err = ERR_FULL;
        end
      end
      ACT_POP: begin
        if (shadow_ptr > 0) begin
          shadow_ptr--;
          r.value = shadow_words[shadow_ptr];
        end else begin
          r.err = ERR_EMPTY;
        end
      end
      ACT_PEEK: begin
        if (shadow_ptr > 0) r.value = shadow_words[shadow_ptr-1];
        else r.err = ERR_EMPTY;
      end
      ACT_DUP: begin
        if (shadow_ptr == 0) begin
          r.err = ERR_EMPTY;
        end else if (shadow_ptr >= DEPTH) begin
          r.err = ERR_FULL;
        end else begin
          shadow_words[shadow_ptr] = shadow_words[shadow_ptr-1];
          shadow_ptr++;
        end
      end
      ACT_SWAP: begin
        if (shadow_ptr > 1) begin
          tmp                        = shadow_words[shadow_ptr-2];
          shadow_words[shadow_ptr-2] = shadow_words[shadow_ptr-1];
          shadow_words[shadow_ptr-1] = tmp;
        end else begin
          r.err = ERR_FEW;
        end
      end
      ACT_CLEAR: shadow_ptr = 0;
      default: ;  // unused codes: no operation
    endcase
    r.depth = DEPTH_W'(shadow_ptr);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (rst) begin
      expected_results.delete();
      shadow_ptr = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(stack_apply(s_tdata[ACT_W-1:0],
                                               s_tdata[ACT_W +: WORD_W]));
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: read_value %h error_code %0d depth %0d",
                 got.value, got.err, got.depth);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, got.value);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, got.err);
            fail_count++;
          end
          if (got.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, got.depth);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### dv/tb_bounded_value_stack_top.sv
// ----------------------------------------------------------------------------
// tb_bounded_value_stack_top: testbench for the bounded value stack
// Drives directed and random stack operations through the input stream,
// throttles both sides, and leaves prediction and checking to the checker.
// ----------------------------------------------------------------------------
module tb_bounded_value_stack_top
  import bvs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 128;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off during the fill
  localparam int STUCK_LIMIT = 5000;  // cycles with no transaction at all
  localparam int DRAIN_TAIL  = 20;    // settle time after the last result

  // Action codes the block does not define; they must act as no-ops.
  localparam logic [ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_7 = 3'd7;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;   // [2:0] action, [66:3] push_value, rest zero
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // [63:0] read_value, [65:64] error_code,
                                     // [73:66] depth, rest zero
  int               fail_count;
  int               pending;

  // Throttle knobs, in percent of cycles spent idle.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req     = 1'b0;  // raised once by the stimulus
  bit          hold_seen    = 1'b0;  // receiver's copy, catches the rise
  int unsigned hold_left    = 0;
  int unsigned stuck_cycles = 0;

  always #5 clk = ~clk;

  bounded_value_stack_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bounded_value_stack_checker #(.DEPTH(DEPTH)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: random backpressure, plus a long hold-off on request. The
  // hold-off is counted here so the sender keeps pushing while it runs.
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_left = HOLD_CYCLES;
    end
    hold_seen = hold_req;
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: any transaction on either channel proves progress.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One input transaction. Called at a falling edge; returns at the falling
  // edge after acceptance with tvalid still high, so back-to-back calls keep
  // the bus busy without dropping valid.
  task automatic send_op(input logic [ACT_W-1:0] op, input logic [WORD_W-1:0] word);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_W-ACT_W-WORD_W){1'b0}}, word, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Sender pause until every expected result has come back.
  task automatic wait_all_results();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mix favours growth so swaps and pops mostly find data; clears and the
  // occasional empty stack still bring in the refusal paths.
  function automatic logic [ACT_W-1:0] rand_op();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 30) return ACT_PUSH;
    if (w < 50) return ACT_POP;
    if (w < 60) return ACT_PEEK;
    if (w < 72) return ACT_DUP;
    if (w < 87) return ACT_SWAP;
    if (w < 92) return ACT_CLEAR;
    if (w < 96) return ACT_UNUSED_6;
    return ACT_UNUSED_7;
  endfunction

  task automatic random_ops(input int unsigned n);
    repeat (n) send_op(rand_op(), rand_word());
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Phase 1: light sender idling, heavy receiver backpressure.
    src_idle_pct = 8;
    snk_idle_pct = 67;

    // Directed: refusals on an empty stack, then a single entry, then two.
    send_op(ACT_POP,   rand_word());
    send_op(ACT_PEEK,  rand_word());
    send_op(ACT_DUP,   rand_word());
    send_op(ACT_SWAP,  rand_word());
    send_op(ACT_PUSH,  '1);
    send_op(ACT_SWAP,  rand_word());   // one entry: too few
    send_op(ACT_PEEK,  '0);
    send_op(ACT_DUP,   '0);
    send_op(ACT_SWAP,  '0);
    send_op(ACT_POP,   '0);
    send_op(ACT_POP,   '0);
    send_op(ACT_POP,   '0);            // empty again
    send_op(ACT_PUSH,  '0);
    send_op(ACT_PUSH,  64'h5555_5555_5555_5555);
    send_op(ACT_PUSH,  64'hAAAA_AAAA_AAAA_AAAA);
    send_op(ACT_SWAP,  '1);
    send_op(ACT_PEEK,  '1);
    send_op(ACT_UNUSED_6, '1);
    send_op(ACT_UNUSED_7, '1);
    send_op(ACT_CLEAR, '1);
    send_op(ACT_PEEK,  '1);            // empty after clear
    send_op(ACT_PUSH,  64'h8000_0000_0000_0001);
    send_op(ACT_POP,   '0);

    // Fill to capacity under a long receiver hold-off: the output queue
    // fills, input stalls, and the full-stack refusals get exercised.
    send_op(ACT_CLEAR, '0);
    hold_req = 1'b1;
    repeat (DEPTH) send_op(ACT_PUSH, rand_word());
    send_op(ACT_PUSH,  rand_word());   // full: dropped
    send_op(ACT_DUP,   rand_word());   // full: refused
    send_op(ACT_PEEK,  '0);
    send_op(ACT_SWAP,  '0);
    send_op(ACT_POP,   '0);
    send_op(ACT_DUP,   '0);            // refills to full
    send_op(ACT_POP,   '0);
    send_op(ACT_POP,   '0);
    send_op(ACT_CLEAR, '0);
    random_ops(100);
    wait_all_results();

    // Phase 2: sender mostly idle, receiver mostly ready.
    src_idle_pct = 67;
    snk_idle_pct = 8;
    random_ops(100);
    wait_all_results();

    // Phase 3: full throughput on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_ops(100);
    wait_all_results();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
